// ===== hdl/cpbf_pkg.sv =====
// shared types and constants of the column predicate bitmap filter
`default_nettype none
package cpbf_pkg;

    localparam int ValueWidth = 64;
    localparam int IndexWidth = 2;
    localparam int ModeWidth  = 3;
    localparam int GroupSize  = 8;
    localparam int CountWidth = 4;
    localparam int PosWidth   = 3;

    // compare modes
    localparam logic [ModeWidth-1:0] MODE_LT      = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_LE      = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_GT      = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_GE      = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_EQ      = 3'd4;
    localparam logic [ModeWidth-1:0] MODE_BETWEEN = 3'd5;

    // element kinds
    localparam logic KIND_U8  = 1'b0;
    localparam logic KIND_S64 = 1'b1;

    // register indexes
    localparam logic [IndexWidth-1:0] REG_COMPARE_MODE = 2'd0;
    localparam logic [IndexWidth-1:0] REG_ELEMENT_KIND = 2'd1;
    localparam logic [IndexWidth-1:0] REG_BOUND_LOW    = 2'd2;
    localparam logic [IndexWidth-1:0] REG_BOUND_HIGH   = 2'd3;

    localparam logic [PosWidth-1:0] LAST_SLOT = 3'd7;

    typedef struct packed {
        logic hit;
        logic last;
    } cpbf_flag_t;

    typedef struct packed {
        logic       valid;
        cpbf_flag_t flag;
    } cpbf_push_t;

    typedef struct packed {
        logic       valid;
        cpbf_flag_t flag;
    } cpbf_pop_t;

    // maps a raw operand onto an unsigned ordering key
    function automatic logic [ValueWidth-1:0] order_key(
        input logic                  kind,
        input logic [ValueWidth-1:0] raw
    );
        logic [ValueWidth-1:0] key;
        if (kind == KIND_S64)
        begin
            key = {~raw[ValueWidth-1], raw[ValueWidth-2:0]};
        end
        else
        begin
            key = {{(ValueWidth-8){1'b0}}, raw[7:0]};
        end
        return key;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/cpbf_row_if.sv =====
// row request channel
`default_nettype none
interface cpbf_row_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_value;
    logic        end_of_block;

    modport source (output valid, output row_value, output end_of_block, input ready);
    modport sink (input valid, input row_value, input end_of_block, output ready);
endinterface
`default_nettype wire

// ===== hdl/cpbf_byte_if.sv =====
// bitmap byte request channel
`default_nettype none
interface cpbf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] match_bits;
    logic [3:0] bit_count;
    logic       last_of_block;

    modport source (output valid, output match_bits, output bit_count,
                    output last_of_block, input ready);
    modport sink (input valid, input match_bits, input bit_count,
                  input last_of_block, output ready);
endinterface
`default_nettype wire

// ===== hdl/cpbf_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface cpbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cpbf_front.sv =====
// front end: configuration registers and row classification
`default_nettype none
module cpbf_front
    import cpbf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cpbf_cfg_if.sink    cfg,
    cpbf_row_if.sink    rows,
    input  wire logic   queue_full,
    output cpbf_push_t  push
);

    logic [ModeWidth-1:0]  mode_reg;
    logic                  kind_reg;
    logic [ValueWidth-1:0] bound_low_reg;
    logic [ValueWidth-1:0] bound_high_reg;

    logic [ValueWidth-1:0] key_val;
    logic [ValueWidth-1:0] key_lo;
    logic [ValueWidth-1:0] key_hi;
    logic                  below_lo;
    logic                  equal_lo;
    logic                  above_hi;
    logic                  hit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LT;
            kind_reg       <= KIND_U8;
            bound_low_reg  <= '0;
            bound_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_COMPARE_MODE: mode_reg       <= cfg.data[ModeWidth-1:0];
                REG_ELEMENT_KIND: kind_reg       <= cfg.data[0];
                REG_BOUND_LOW:    bound_low_reg  <= cfg.data;
                REG_BOUND_HIGH:   bound_high_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign key_val  = order_key(kind_reg, rows.row_value);
    assign key_lo   = order_key(kind_reg, bound_low_reg);
    assign key_hi   = order_key(kind_reg, bound_high_reg);
    assign below_lo = key_val < key_lo;
    assign equal_lo = key_val == key_lo;
    assign above_hi = key_val > key_hi;

    always_comb
    begin
        case (mode_reg)
            MODE_LT:      hit = below_lo;
            MODE_LE:      hit = below_lo | equal_lo;
            MODE_GT:      hit = ~(below_lo | equal_lo);
            MODE_GE:      hit = ~below_lo;
            MODE_EQ:      hit = equal_lo;
            MODE_BETWEEN: hit = ~below_lo & ~above_hi;
            default:      hit = 1'b0;
        endcase
    end

    assign rows.ready     = ~queue_full;
    assign push.valid     = rows.valid & ~queue_full;
    assign push.flag.hit  = hit;
    assign push.flag.last = rows.end_of_block;

endmodule
`default_nettype wire

// ===== hdl/cpbf_queue.sv =====
// short flag queue between front and back
`default_nettype none
module cpbf_queue
    import cpbf_pkg::*;
#(
    parameter int Depth = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cpbf_push_t  push,
    input  wire logic        pop_take,
    output cpbf_pop_t        pop,
    output logic             full
);

    localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountBits  = $clog2(Depth + 1);

    cpbf_flag_t             mem_reg [Depth];
    logic [PtrWidth-1:0]    wr_ptr_reg;
    logic [PtrWidth-1:0]    rd_ptr_reg;
    logic [CountBits-1:0]   count_reg;
    logic [CountBits-1:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = count_reg == CountBits'(Depth);
    assign pop.valid = count_reg != '0;
    assign pop.flag  = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid & ~full;
    assign do_pop    = pop_take & pop.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push & ~do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop & ~do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.flag;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountBits'(Depth))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PtrWidth'(Depth - 1) && rd_ptr_reg <= PtrWidth'(Depth - 1)))
        else $error("queue pointer beyond depth");
`endif

endmodule
`default_nettype wire

// ===== hdl/cpbf_back.sv =====
// back end: packs match flags into bitmap bytes
`default_nettype none
module cpbf_back
    import cpbf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cpbf_pop_t pop,
    output logic         pop_take,
    cpbf_byte_if.source  bytes
);

    logic [GroupSize-1:0]  partial_reg;
    logic [GroupSize-1:0]  partial_next;
    logic [PosWidth-1:0]   pos_reg;
    logic [PosWidth-1:0]   pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [GroupSize-1:0]  out_bits_reg;
    logic [CountWidth-1:0] out_count_reg;
    logic                  out_last_reg;
    logic [GroupSize-1:0]  merged;
    logic                  emit;

    assign pop_take = ~out_valid_reg | bytes.ready;
    assign merged   = partial_reg | ({{(GroupSize-1){1'b0}}, pop.flag.hit} << pos_reg);
    assign emit     = (pos_reg == LAST_SLOT) | pop.flag.last;

    always_comb
    begin
        partial_next   = partial_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg & ~bytes.ready;
        if (pop.valid & pop_take)
        begin
            if (emit)
            begin
                partial_next   = '0;
                pos_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                partial_next = merged;
                pos_next     = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop.valid & pop_take & emit)
        begin
            out_bits_reg  <= merged;
            out_count_reg <= {1'b0, pos_reg} + 1'b1;
            out_last_reg  <= pop.flag.last;
        end
    end

    assign bytes.valid         = out_valid_reg;
    assign bytes.match_bits    = out_bits_reg;
    assign bytes.bit_count     = out_count_reg;
    assign bytes.last_of_block = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != '0 && out_count_reg <= CountWidth'(GroupSize)))
        else $error("byte row count out of range");
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop.valid && pop_take && emit) |=> (pos_reg == '0 && partial_reg == '0))
        else $error("packer not cleared after byte");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bytes.ready) |-> !pop_take)
        else $error("flag taken while byte stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/column_predicate_bitmap_filter.sv =====
// top level of the column predicate bitmap filter
//
// usage
//   cfg   : register writes (index, data); always ready. registers are
//           compare mode, element kind, lower bound and upper bound, all
//           zero after reset. write them only while the filter is idle.
//   rows  : one column value per request with an end-of-block flag.
//   bytes : packed match flags, row k of the group in bit k, with the row
//           count of the byte and a block-closing flag.
//   a byte leaves after the eighth row of a group or after a row that ends
//   the block; that row's flag passes the flag queue, then the byte register.
//   throughput is one row per cycle while the queue is not full, set by
//   the 64-bit compares in the front end and a one-flag-per-cycle packer
//   in the back end. a queue of QUEUE_DEPTH flags sits between the two; when
//   the receiver stalls the output byte holds, the packer stops, and rows
//   keep being taken until the queue fills, then rows.ready drops.
//   reset empties the queue and packer and clears the output valid.
`default_nettype none
module column_predicate_bitmap_filter
    import cpbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    cpbf_cfg_if.sink     cfg,
    cpbf_row_if.sink     rows,
    cpbf_byte_if.source  bytes
);

    cpbf_push_t push;
    cpbf_pop_t  pop;
    logic       queue_full;
    logic       pop_take;

    cpbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .rows       (rows),
        .queue_full (queue_full),
        .push       (push)
    );

    cpbf_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop_take (pop_take),
        .pop      (pop),
        .full     (queue_full)
    );

    cpbf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_take (pop_take),
        .bytes    (bytes)
    );

endmodule
`default_nettype wire
